FILE: rtl/keypad_event_to_key_decoder_core_defines.svh
// Assertion helpers for the keypad decoder. Clock clk, reset arst_n.
`ifndef KEYPAD_EVENT_TO_KEY_DECODER_CORE_DEFINES_SVH
`define KEYPAD_EVENT_TO_KEY_DECODER_CORE_DEFINES_SVH

// same-cycle implication
`define KPD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("keypad decoder check failed");

// next-cycle implication
`define KPD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("keypad decoder check failed");

`endif

FILE: rtl/kpd_pkg.sv
package kpd_pkg;

	localparam int EVENT_W      = 8;
	localparam int KIND_W       = 4;
	localparam int CHAR_W       = 7;
	localparam int ROWS         = 4;
	localparam int COLS         = 14;
	localparam int KEYS_PER_ROW = 10;
	localparam int QUEUE_DEPTH  = 2;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_CHAR  = 4'd0;
	localparam logic [KIND_W-1:0] KIND_ESC   = 4'd1;
	localparam logic [KIND_W-1:0] KIND_BKSP  = 4'd2;
	localparam logic [KIND_W-1:0] KIND_TAB   = 4'd3;
	localparam logic [KIND_W-1:0] KIND_ENTER = 4'd4;
	localparam logic [KIND_W-1:0] KIND_UP    = 4'd5;
	localparam logic [KIND_W-1:0] KIND_DOWN  = 4'd6;
	localparam logic [KIND_W-1:0] KIND_LEFT  = 4'd7;
	localparam logic [KIND_W-1:0] KIND_RIGHT = 4'd8;

	// control characters for the bracket group
	localparam logic [CHAR_W-1:0] CTL_LBRACK = 7'h1B;
	localparam logic [CHAR_W-1:0] CTL_BSLASH = 7'h1C;
	localparam logic [CHAR_W-1:0] CTL_RBRACK = 7'h1D;
	localparam logic [CHAR_W-1:0] CTL_CARET  = 7'h1E;
	localparam logic [CHAR_W-1:0] CTL_UNDER  = 7'h1F;

	typedef enum logic [1:0] {
		CLS_FN,
		CLS_SHIFT,
		CLS_CTRL,
		CLS_KEY
	} ev_class_t;

	// one classified event in the queue
	typedef struct packed {
		ev_class_t   cls;
		logic        press;
		logic [1:0]  row;
		logic [3:0]  col;
	} kev_t;

	// leftmost character of each string is column 0
	localparam logic [COLS*8-1:0] PLAIN_ROM [ROWS] = '{
		" 1234567890-= ",
		" qwertyuiop[]\\",
		"  asdfghjkl;' ",
		"   zxcvbnm,./ "
	};

	localparam logic [COLS*8-1:0] UPPER_ROM [ROWS] = '{
		" !@#$%^&*()_+ ",
		" QWERTYUIOP{}|",
		"  ASDFGHJKL:\" ",
		"   ZXCVBNM<>? "
	};

	function automatic logic [CHAR_W-1:0] sym_of(input logic shift, input logic [1:0] row,
		input logic [3:0] col);
		logic [COLS*8-1:0] line;
		logic [7:0]        ch;
		line = shift ? UPPER_ROM[row] : PLAIN_ROM[row];
		ch   = line[(COLS-1-col)*8 +: 8];
		return ch[CHAR_W-1:0];
	endfunction

	function automatic logic [KIND_W-1:0] special_kind(input logic [1:0] row,
		input logic [3:0] col);
		logic [KIND_W-1:0] k;
		k = KIND_CHAR;
		case ({row, col})
			{2'd0, 4'd0}:  k = KIND_ESC;
			{2'd0, 4'd13}: k = KIND_BKSP;
			{2'd1, 4'd0}:  k = KIND_TAB;
			{2'd2, 4'd13}: k = KIND_ENTER;
			default:       k = KIND_CHAR;
		endcase
		return k;
	endfunction

	// KIND_CHAR here means the key has no fn meaning
	function automatic logic [KIND_W-1:0] fn_kind(input logic [1:0] row,
		input logic [3:0] col);
		logic [KIND_W-1:0] k;
		k = KIND_CHAR;
		case ({row, col})
			{2'd2, 4'd11}: k = KIND_UP;
			{2'd3, 4'd10}: k = KIND_LEFT;
			{2'd3, 4'd11}: k = KIND_DOWN;
			{2'd3, 4'd12}: k = KIND_RIGHT;
			default:       k = KIND_CHAR;
		endcase
		return k;
	endfunction

	function automatic logic [CHAR_W-1:0] ctl_of(input logic [CHAR_W-1:0] ch);
		logic [CHAR_W-1:0] c;
		c = '0;
		if (ch inside {[7'h61:7'h7A]}) begin
			c = ch - 7'h60;
		end else if (ch inside {[7'h41:7'h5A]}) begin
			c = ch - 7'h40;
		end else begin
			case (ch)
				7'h5B:   c = CTL_LBRACK;
				7'h5C:   c = CTL_BSLASH;
				7'h5D:   c = CTL_RBRACK;
				7'h5E:   c = CTL_CARET;
				7'h5F:   c = CTL_UNDER;
				default: c = '0;
			endcase
		end
		return c;
	endfunction

endpackage

FILE: rtl/kpd_front.sv
module kpd_front (
	input  logic [kpd_pkg::EVENT_W-1:0] event_code,
	output logic                        keep,
	output kpd_pkg::kev_t               kev
);
	import kpd_pkg::*;

	logic [6:0]  idx;
	logic [14:0] prod;
	logic [3:0]  rr;
	logic [3:0]  rc;
	logic [4:0]  col;
	logic [6:0]  rr_x10;

	// key numbers start at one; zero folds onto key one
	assign idx    = (event_code[6:0] == 7'd0) ? 7'd0 : event_code[6:0] - 7'd1;
	// idx / 10 by reciprocal, exact for all 7-bit idx
	assign prod   = {8'd0, idx} * 15'd205;
	assign rr     = prod[14:11];
	assign rr_x10 = {3'd0, rr} * 7'(KEYS_PER_ROW);
	assign rc     = 4'(idx - rr_x10);
	assign col    = {rr, 1'b0} + {4'd0, (rc > 4'd3)};

	always_comb begin
		kev.press = event_code[EVENT_W-1];
		kev.row   = rc[1:0];
		kev.col   = col[3:0];
		kev.cls   = CLS_KEY;
		if (kev.row == 2'd2 && col == 5'd0) begin
			kev.cls = CLS_FN;
		end else if (kev.row == 2'd2 && col == 5'd1) begin
			kev.cls = CLS_SHIFT;
		end else if (kev.row == 2'd3 && col <= 5'd2) begin
			kev.cls = CLS_CTRL;
		end
		// off-layout keys and releases of plain keys leave no trace
		keep = (col < 5'(COLS)) && (kev.cls != CLS_KEY || kev.press);
	end

endmodule

FILE: rtl/kpd_fifo.sv
module kpd_fifo #(
	parameter int DEPTH = kpd_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  kpd_pkg::kev_t push_data,
	output logic          ready,
	output logic          valid,
	input  logic          pop,
	output kpd_pkg::kev_t pop_data
);
	import kpd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	kev_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign ready    = (count_q != CNT_W'(DEPTH));
	assign valid    = (count_q != '0);
	assign pop_data = mem_q[rptr_q];
	assign do_push  = push && ready;
	assign do_pop   = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/kpd_back.sv
module kpd_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  kpd_pkg::kev_t               q_data,
	output logic                        q_pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [kpd_pkg::KIND_W-1:0]  out_kind,
	output logic [kpd_pkg::CHAR_W-1:0]  out_char
);
	import kpd_pkg::*;

	logic fn_held_q, fn_sticky_q, shift_held_q, ctrl_held_q, ctrl_sticky_q;
	logic out_valid_q;
	logic [KIND_W-1:0] out_kind_q;
	logic [CHAR_W-1:0] out_char_q;

	logic              use_fn, use_mod;
	logic [KIND_W-1:0] fk, sk;
	logic [CHAR_W-1:0] sym, ctl;

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_char  = out_char_q;
	// the slot is free or empties this cycle
	assign q_pop     = q_valid && (!out_valid_q || out_ready);

	assign use_fn  = fn_held_q || fn_sticky_q;
	assign use_mod = use_fn || ctrl_held_q || ctrl_sticky_q;
	assign fk      = fn_kind(q_data.row, q_data.col);
	assign sk      = special_kind(q_data.row, q_data.col);
	assign sym     = sym_of(shift_held_q, q_data.row, q_data.col);
	assign ctl     = ctl_of(sym);

	always_ff @(posedge clk) begin
		if (q_pop && q_data.cls == CLS_KEY) begin
			if (use_fn && fk != KIND_CHAR) begin
				out_kind_q <= fk;
				out_char_q <= '0;
			end else if (sk != KIND_CHAR) begin
				out_kind_q <= sk;
				out_char_q <= '0;
			end else begin
				out_kind_q <= KIND_CHAR;
				out_char_q <= (use_mod && ctl != '0) ? ctl : sym;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fn_held_q     <= 1'b0;
			fn_sticky_q   <= 1'b0;
			shift_held_q  <= 1'b0;
			ctrl_held_q   <= 1'b0;
			ctrl_sticky_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (q_pop && q_data.cls == CLS_KEY) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				case (q_data.cls)
					CLS_FN: begin
						fn_held_q <= q_data.press;
						if (q_data.press) fn_sticky_q <= 1'b1;
					end
					CLS_SHIFT: begin
						shift_held_q <= q_data.press;
					end
					CLS_CTRL: begin
						ctrl_held_q <= q_data.press;
						if (q_data.press) ctrl_sticky_q <= 1'b1;
					end
					CLS_KEY: begin
						fn_sticky_q <= 1'b0;
						// an fn arrow keeps the ctrl latch
						if (!(use_fn && fk != KIND_CHAR)) ctrl_sticky_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

FILE: rtl/keypad_event_to_key_decoder_core.sv
// Keypad event decoder. Each beat on the s_ side is one raw controller event byte
// (bit 7 press, bits 6..0 key number from one); each beat on the m_ side is one decoded
// key. The front folds the key number onto a 4 by 14 layout and sorts it into fn,
// shift, ctrl or an ordinary key, dropping releases of ordinary keys and keys off the
// layout; a short queue carries the rest to the back, which keeps the modifier and
// sticky-latch state and looks the key up in constant tables. One event is taken every
// cycle while the queue has room; a decoded key passes through the queue, then the output
// register, and only the depth of the queue and a stalled m_tready hold up s_tready.
module keypad_event_to_key_decoder_core #(
	parameter int QUEUE_DEPTH = kpd_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] event_code
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [6:0] char_code, [7] zero
	output logic [3:0] m_tuser    // [3:0] key_kind
);
	import kpd_pkg::*;

	`include "keypad_event_to_key_decoder_core_defines.svh"

	logic              keep;
	kev_t              kev_in;
	kev_t              kev_out;
	logic              q_ready, q_valid, q_pop;
	logic [CHAR_W-1:0] char_code;

	// front: fold and classify, combinational into the queue
	kpd_front u_front (
		.event_code (s_tdata),
		.keep       (keep),
		.kev        (kev_in)
	);

	// every beat is taken while the queue has room, dropped ones included
	assign s_tready = q_ready;

	kpd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s_tvalid && keep),
		.push_data (kev_in),
		.ready     (q_ready),
		.valid     (q_valid),
		.pop       (q_pop),
		.pop_data  (kev_out)
	);

	// back: modifier state, table lookup and the output register
	kpd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (kev_out),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_kind  (m_tuser),
		.out_char  (char_code)
	);

	assign m_tdata = {1'b0, char_code};

	// only defined kinds leave the block
	`KPD_ASSERT_NOW(a_kind_range, m_tvalid, m_tuser <= KIND_RIGHT)
	// special keys and arrows carry no character
	`KPD_ASSERT_NOW(a_special_no_char, m_tvalid && m_tuser != KIND_CHAR, m_tdata == 8'd0)
	// a queued event not drained yet is still there next cycle
	`KPD_ASSERT_NEXT(a_queue_holds, q_valid && !q_pop, q_valid)

endmodule
